[rtl/core/jfb_pkg.sv]
// Shared types, constants and the axis centering function of the joystick frame builder.
`timescale 1ns / 1ps

package jfb_pkg;

    localparam int AXIS_W = 8;

    // Command codes carried on s_tuser.
    localparam logic CMD_CALIBRATE = 1'b0;
    localparam logic CMD_SAMPLE    = 1'b1;

    // Register indexes, decoded from paddr[2].
    localparam logic REG_ARM_THRESHOLD     = 1'b0;
    localparam logic REG_BATTERY_LOW_LEVEL = 1'b1;

    localparam logic [AXIS_W-1:0] AXIS_MID            = 8'd128;
    localparam logic [AXIS_W-1:0] AXIS_MAX            = 8'd255;
    localparam logic [AXIS_W-1:0] ARM_THRESHOLD_RST   = 8'd20;
    // Largest raw count whose scaled voltage raw*505/256 stays at or below 3.70 V.
    localparam logic [AXIS_W-1:0] BATTERY_LOW_RST     = 8'd187;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    typedef struct packed {
        logic              cmd;
        logic              left_key_pressed;
        logic              right_key_pressed;
        logic [AXIS_W-1:0] battery_raw;
        logic [AXIS_W-1:0] throttle_raw;
        logic [AXIS_W-1:0] yaw_raw;
        logic [AXIS_W-1:0] roll_raw;
        logic [AXIS_W-1:0] pitch_raw;
    } item_t;

    // Packed with the last field, sequence_res, in the lowest bits.
    typedef struct packed {
        logic              battery_low;
        logic              armed_flag;
        logic              left_key;
        logic              right_key;
        logic [AXIS_W-1:0] throttle_out;
        logic [AXIS_W-1:0] yaw_out;
        logic [AXIS_W-1:0] roll_out;
        logic [AXIS_W-1:0] pitch_out;
        logic [AXIS_W-1:0] sequence_res;
    } frame_t;

    localparam int FRAME_W = $bits(frame_t);

    typedef struct packed {
        logic [AXIS_W-1:0] arm_threshold;
        logic [AXIS_W-1:0] battery_low_level;
    } cfg_t;

    typedef struct packed {
        logic take;
        logic armed;
    } core_status_t;

    // raw - center + 128, clamped to 0..255.
    function automatic logic [AXIS_W-1:0] center_axis(
        input logic [AXIS_W-1:0] raw,
        input logic [AXIS_W-1:0] center
    );
        logic signed [AXIS_W+1:0] diff;
        logic [AXIS_W-1:0]        res;
        diff = $signed({2'b00, raw}) - $signed({2'b00, center})
             + $signed({2'b00, AXIS_MID});
        if (diff >= $signed({2'b00, AXIS_MAX})) begin
            res = AXIS_MAX;
        end else if (diff <= $signed({(AXIS_W+2){1'b0}})) begin
            res = '0;
        end else begin
            res = diff[AXIS_W-1:0];
        end
        return res;
    endfunction

endpackage

[rtl/core/jfb_apb_regs.sv]
// APB register file holding the arm threshold and the battery low level.
`timescale 1ns / 1ps

module jfb_apb_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [jfb_pkg::PADDR_W-1:0]  paddr,
    input  logic [jfb_pkg::PDATA_W-1:0]  pwdata,
    output logic [jfb_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output jfb_pkg::cfg_t                cfg
);
    import jfb_pkg::*;

    logic [AXIS_W-1:0] arm_threshold_reg;
    logic [AXIS_W-1:0] battery_low_level_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_threshold_reg     <= ARM_THRESHOLD_RST;
            battery_low_level_reg <= BATTERY_LOW_RST;
        end else if (wr_en) begin
            if (paddr[2] == REG_ARM_THRESHOLD) begin
                arm_threshold_reg <= pwdata[AXIS_W-1:0];
            end else begin
                battery_low_level_reg <= pwdata[AXIS_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_ARM_THRESHOLD:     prdata[AXIS_W-1:0] = arm_threshold_reg;
            REG_BATTERY_LOW_LEVEL: prdata[AXIS_W-1:0] = battery_low_level_reg;
            default:               prdata = '0;
        endcase
    end

    assign cfg.arm_threshold     = arm_threshold_reg;
    assign cfg.battery_low_level = battery_low_level_reg;

endmodule

[rtl/core/jfb_in_stage.sv]
// Input register stage that captures one stream beat and holds it until the core takes it.
`timescale 1ns / 1ps

module jfb_in_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [jfb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          take,
    output logic                          item_valid,
    output jfb_pkg::item_t                item
);
    import jfb_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign s_tready   = !valid_reg || take;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg.cmd               <= s_tuser;
            item_reg.pitch_raw         <= s_tdata[7:0];
            item_reg.roll_raw          <= s_tdata[15:8];
            item_reg.yaw_raw           <= s_tdata[23:16];
            item_reg.throttle_raw      <= s_tdata[31:24];
            item_reg.battery_raw       <= s_tdata[39:32];
            item_reg.right_key_pressed <= s_tdata[40];
            item_reg.left_key_pressed  <= s_tdata[41];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/core/jfb_frame_core.sv]
// Stick state, arming, sequence counting and the registered result frame.
`timescale 1ns / 1ps

module jfb_frame_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    input  jfb_pkg::item_t                item,
    input  jfb_pkg::cfg_t                 cfg,
    output jfb_pkg::core_status_t         status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [jfb_pkg::M_TDATA_W-1:0] m_tdata
);
    import jfb_pkg::*;

    logic [AXIS_W-1:0] pitch_center_reg;
    logic [AXIS_W-1:0] roll_center_reg;
    logic [AXIS_W-1:0] yaw_center_reg;
    logic              armed_reg;
    logic              armed_next;
    logic [AXIS_W-1:0] seq_reg;
    logic [AXIS_W-1:0] seq_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    frame_t            frame_reg;
    frame_t            frame_next;

    logic is_sample;
    logic out_room;
    logic take;
    logic take_sample;
    logic take_cal;
    logic arm_now;

    assign is_sample   = (item.cmd == CMD_SAMPLE);
    assign out_room    = !out_valid_reg || m_tready;
    // A calibrate beat gives no frame, so it never waits for the output side.
    assign take        = item_valid && (!is_sample || out_room);
    assign take_sample = take && is_sample;
    assign take_cal    = take && !is_sample;

    assign arm_now    = !armed_reg && (item.throttle_raw < cfg.arm_threshold);
    assign armed_next = armed_reg || arm_now;
    // The arming sample advances the counter twice.
    assign seq_next   = seq_reg + (arm_now ? AXIS_W'(2) : AXIS_W'(1));

    always_comb begin
        frame_next.sequence_res = seq_next;
        frame_next.right_key    = item.right_key_pressed;
        frame_next.left_key     = item.left_key_pressed;
        frame_next.armed_flag   = armed_next;
        frame_next.battery_low  = (item.battery_raw <= cfg.battery_low_level);
        if (armed_next) begin
            frame_next.pitch_out    = center_axis(item.pitch_raw, pitch_center_reg);
            frame_next.roll_out     = center_axis(item.roll_raw, roll_center_reg);
            frame_next.yaw_out      = center_axis(item.yaw_raw, yaw_center_reg);
            frame_next.throttle_out = item.throttle_raw;
        end else begin
            frame_next.pitch_out    = AXIS_MID;
            frame_next.roll_out     = AXIS_MID;
            frame_next.yaw_out      = AXIS_MID;
            frame_next.throttle_out = '0;
        end
    end

    assign out_valid_next = take_sample || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_center_reg <= AXIS_MID;
            roll_center_reg  <= AXIS_MID;
            yaw_center_reg   <= AXIS_MID;
            armed_reg        <= 1'b0;
            seq_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take_cal) begin
                pitch_center_reg <= item.pitch_raw;
                roll_center_reg  <= item.roll_raw;
                yaw_center_reg   <= item.yaw_raw;
            end
            if (take_sample) begin
                armed_reg <= armed_next;
                seq_reg   <= seq_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_sample) begin
            frame_reg <= frame_next;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {{(M_TDATA_W-FRAME_W){1'b0}}, frame_reg};
    assign status.take  = take;
    assign status.armed = armed_reg;

endmodule

[rtl/core/joystick_frame_builder.sv]
// Top level of the joystick frame builder: input stage, frame core and register file.
`timescale 1ns / 1ps

// Takes one beat per clock while s_tready is high. A calibrate beat (s_tuser low) stores
// the pitch, roll and yaw readings as stick centers and yields no output; a sample beat
// (s_tuser high) yields one 48-bit control frame through the input and result registers,
// when m_tready allows. Both the input register and the result register can hold a beat,
// so the block keeps accepting while a finished frame waits; s_tready falls only when
// the result register is full and not taken and a sample beat waits behind it. Arming
// latches on the first sample whose raw throttle is below arm_threshold (APB 0x0);
// battery_low compares the raw battery count against battery_low_level (APB 0x4). The
// user writes configuration only while no beat is in flight; the block does not enforce it.
module joystick_frame_builder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pitch_raw[7:0], roll_raw[15:8], yaw_raw[23:16], throttle_raw[31:24],
    // battery_raw[39:32], right_key_pressed[40], left_key_pressed[41], zero[47:42]
    input  logic [jfb_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd[0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // sequence_res[7:0], pitch_out[15:8], roll_out[23:16], yaw_out[31:24],
    // throttle_out[39:32], right_key[40], left_key[41], armed_flag[42],
    // battery_low[43], zero[47:44]
    output logic [jfb_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jfb_pkg::PADDR_W-1:0]   paddr,
    input  logic [jfb_pkg::PDATA_W-1:0]   pwdata,
    output logic [jfb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import jfb_pkg::*;

    cfg_t         cfg;
    core_status_t status;
    item_t        item;
    logic         item_valid;

    jfb_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    jfb_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (status.take),
        .item_valid (item_valid),
        .item       (item)
    );

    jfb_frame_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .cfg        (cfg),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // Once latched, arming never clears short of reset.
    a_armed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        status.armed |=> status.armed)
        else $error("arming cleared without reset");

    // A frame that is not armed carries neutral axes and zero throttle.
    a_neutral_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[42]) |->
            (m_tdata[15:8] == AXIS_MID && m_tdata[23:16] == AXIS_MID &&
             m_tdata[31:24] == AXIS_MID && m_tdata[39:32] == '0))
        else $error("unarmed frame is not neutral");

    // Input back-pressure only comes from a stalled result register.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    // A calibrate beat in the input register is always taken at once.
    a_core_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && item.cmd == CMD_CALIBRATE) |-> status.take)
        else $error("calibrate beat was held in the input stage");

endmodule
